// ===== design/mlw_pkg.sv =====
// ----------------------------------------------------------------------------
// mlw_pkg - shared types and constants of the multi-lifeline watchdog
// Item kinds, result kinds, field widths and the cell control/status structs.
// ----------------------------------------------------------------------------
package mlw_pkg;

  localparam int LINE_COUNT_DEF = 8;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int RKIND_W  = 3;
  localparam int SLOT_W   = 3;
  localparam int MASK_W   = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_FEED  = 2'd2,
    KIND_CHECK = 2'd3
  } item_kind_t;

  typedef enum logic [RKIND_W-1:0] {
    RES_CLEAR   = 3'd0,
    RES_ADD     = 3'd1,
    RES_FEED    = 3'd2,
    RES_EVENT   = 3'd3,
    RES_SUMMARY = 3'd4
  } res_kind_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              clear;
    logic              add;
    logic              feed;
    logic              start;      // check item accepted: sample overdue state
    logic              step;       // scan token moves one cell
    logic              events_en;
    logic [ID_W-1:0]   line_id;
    logic [TIME_W-1:0] max_age_ms;
    logic [TIME_W-1:0] now_ms;
  } cell_op_t;

  // status of one cell back to the controller
  typedef struct packed {
    logic claim;   // lowest free cell
    logic hit;     // feed target, armed
    logic ov;      // overdue at last check
    logic pend;    // new breach at last check: event due
    logic token;   // scan token sits here
  } cell_stat_t;

endpackage

// ===== design/mlw_in_if.sv =====
// ----------------------------------------------------------------------------
// mlw_in_if - input item channel
// Valid/ready channel carrying one watchdog request item.
// ----------------------------------------------------------------------------
interface mlw_in_if;
  import mlw_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   line_id;
  logic [TIME_W-1:0] max_age_ms;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, kind, line_id, max_age_ms, now_ms, input ready);
  modport sink   (input valid, kind, line_id, max_age_ms, now_ms, output ready);
endinterface

// ===== design/mlw_out_if.sv =====
// ----------------------------------------------------------------------------
// mlw_out_if - result item channel
// Valid/ready channel carrying one watchdog result item.
// ----------------------------------------------------------------------------
interface mlw_out_if;
  import mlw_pkg::*;

  logic               valid;
  logic               ready;
  logic [RKIND_W-1:0] result_kind;
  logic [SLOT_W-1:0]  slot;
  logic               ok;
  logic [MASK_W-1:0]  overdue_mask;
  logic               last;

  modport source (output valid, result_kind, slot, ok, overdue_mask, last, input ready);
  modport sink   (input valid, result_kind, slot, ok, overdue_mask, last, output ready);
endinterface

// ===== design/mlw_cell.sv =====
// ----------------------------------------------------------------------------
// mlw_cell - one lifeline
// Holds armed/breach marks, deadline and last feed time; passes the free-slot
// chain and the check scan token to its neighbor.
// ----------------------------------------------------------------------------
module mlw_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mlw_pkg::cell_op_t op,
  input  logic              free_in,
  output logic              free_out,
  input  logic              token_in,
  output mlw_pkg::cell_stat_t stat
);
  import mlw_pkg::*;

  logic              armed_r, armed_nxt;
  logic              breach_r, breach_nxt;
  logic              pend_r, pend_nxt;
  logic              ov_r, ov_nxt;
  logic              token_r, token_nxt;
  logic [TIME_W-1:0] deadline_r, deadline_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  logic [TIME_W-1:0] age;
  logic              ov_now;
  logic              claim;
  logic              hit;

  assign age      = op.now_ms - last_r;       // wraps mod 2^32
  assign ov_now   = armed_r && (age > deadline_r);
  assign claim    = !armed_r && !free_in;
  assign hit      = armed_r && (op.line_id == ID_W'(INDEX));
  assign free_out = free_in || !armed_r;

  always_comb begin
    armed_nxt    = armed_r;
    breach_nxt   = breach_r;
    pend_nxt     = pend_r;
    ov_nxt       = ov_r;
    deadline_nxt = deadline_r;
    last_nxt     = last_r;
    token_nxt    = (op.start || op.step) ? token_in : token_r;
    priority if (op.clear) begin
      armed_nxt  = 1'b0;
      breach_nxt = 1'b0;
      pend_nxt   = 1'b0;
      ov_nxt     = 1'b0;
    end else if (op.add && claim) begin
      armed_nxt    = 1'b1;
      breach_nxt   = 1'b0;
      deadline_nxt = op.max_age_ms;
      last_nxt     = op.now_ms;
    end else if (op.feed && hit) begin
      breach_nxt = 1'b0;
      last_nxt   = op.now_ms;
    end else if (op.start) begin
      ov_nxt   = ov_now;
      pend_nxt = ov_now && !breach_r && op.events_en;
      if (ov_now) begin
        breach_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      breach_r <= 1'b0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
      token_r  <= 1'b0;
    end else begin
      armed_r  <= armed_nxt;
      breach_r <= breach_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
      token_r  <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    last_r     <= last_nxt;
  end

  assign stat.claim = claim;
  assign stat.hit   = hit;
  assign stat.ov    = ov_r;
  assign stat.pend  = pend_r;
  assign stat.token = token_r;

endmodule

// ===== design/multi_lifeline_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_lifeline_watchdog - table of watchdog lifelines
// Row of lifeline cells with a small controller and one output register.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      kind, line_id, max_age_ms, now_ms
//  out_ch    out  valid/ready      result_kind, slot, ok, overdue_mask, last
//  cfg_*     in   write enable     breach_events_enabled (1 bit)
//
//  The reply to a clear, add or feed goes to the output
//  register in the accept cycle. A check samples every cell when it is
//  accepted; then the scan token walks the cell row (one breach event per
//  cycle where due); then the summary is sent.
//  rst_n is synchronous, active low; it clears marks and the enable bit.
//  A stalled out_ch freezes the scan; a new item is taken only when idle and
//  the output register is free or being drained.
// ----------------------------------------------------------------------------
module multi_lifeline_watchdog #(
  parameter int LINE_COUNT = mlw_pkg::LINE_COUNT_DEF
) (
  input logic clk,
  input logic rst_n,
  mlw_in_if.sink    in_ch,
  mlw_out_if.source out_ch,
  input logic cfg_wr_en,
  input logic cfg_wr_data
);
  import mlw_pkg::*;

  localparam int EXT_W = (LINE_COUNT > MASK_W) ? LINE_COUNT : MASK_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SUM  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   en_r, en_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [RKIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [MASK_W-1:0]  out_mask_r, out_mask_nxt;
  logic               out_last_r, out_last_nxt;

  logic out_free;
  logic acc;

  cell_op_t   op;
  cell_stat_t stat [LINE_COUNT];
  logic [LINE_COUNT:0]   free_c;
  logic [LINE_COUNT-1:0] tok_in;

  // flattened cell status
  logic [LINE_COUNT-1:0] claim_v, hit_v, ov_v, pend_v, tok_v;
  logic [EXT_W-1:0]      ov_ext;

  logic [SLOT_W-1:0] add_slot;
  logic              add_ok;
  logic              feed_ok;
  logic [SLOT_W-1:0] ev_slot;
  logic              ev_hit;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;

  // broadcast to the row
  assign op.clear       = acc && (in_ch.kind == KIND_CLEAR);
  assign op.add         = acc && (in_ch.kind == KIND_ADD);
  assign op.feed        = acc && (in_ch.kind == KIND_FEED);
  assign op.start       = acc && (in_ch.kind == KIND_CHECK);
  assign op.step        = (state_r == S_SCAN) && out_free;
  assign op.events_en   = en_r;
  assign op.line_id     = in_ch.line_id;
  assign op.max_age_ms  = in_ch.max_age_ms;
  assign op.now_ms      = in_ch.now_ms;

  // the row of cells: free chain flows up, scan token walks up
  assign free_c[0] = 1'b0;

  for (genvar i = 0; i < LINE_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = op.start;
    end else begin : g_link
      assign tok_in[i] = stat[i-1].token;
    end

    mlw_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .free_in  (free_c[i]),
      .free_out (free_c[i+1]),
      .token_in (tok_in[i]),
      .stat     (stat[i])
    );

    assign claim_v[i] = stat[i].claim;
    assign hit_v[i]   = stat[i].hit;
    assign ov_v[i]    = stat[i].ov;
    assign pend_v[i]  = stat[i].pend;
    assign tok_v[i]   = stat[i].token;
  end

  // free chain ends high when some slot was free
  assign add_ok  = free_c[LINE_COUNT];
  assign feed_ok = |hit_v;
  assign ev_hit  = |(tok_v & pend_v);
  assign ov_ext  = EXT_W'(ov_v);

  // slot numbers are cut to the field width for large tables
  always_comb begin
    add_slot = '0;
    ev_slot  = '0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      if (claim_v[i]) begin
        add_slot = add_slot | SLOT_W'(i);
      end
      if (tok_v[i]) begin
        ev_slot = ev_slot | SLOT_W'(i);
      end
    end
  end

  // controller and output register
  always_comb begin
    state_nxt     = state_r;
    en_nxt        = en_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_ok_nxt    = out_ok_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) begin
      en_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_slot_nxt = '0;
          out_ok_nxt   = 1'b0;
          out_mask_nxt = '0;
          out_last_nxt = 1'b1;
          unique case (in_ch.kind)
            KIND_CLEAR: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = RES_CLEAR;
              en_nxt        = 1'b0;   // clearing forgets the handler
            end
            KIND_ADD: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = RES_ADD;
              out_ok_nxt    = add_ok;
              out_slot_nxt  = add_ok ? add_slot : '0;
            end
            KIND_FEED: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = RES_FEED;
              out_ok_nxt    = feed_ok;
            end
            KIND_CHECK: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (op.step) begin
          if (ev_hit) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = RES_EVENT;
            out_slot_nxt  = ev_slot;
            out_ok_nxt    = 1'b0;
            out_mask_nxt  = '0;
            out_last_nxt  = 1'b0;
          end
          if (tok_v[LINE_COUNT-1]) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RES_SUMMARY;
          out_slot_nxt  = '0;
          out_ok_nxt    = 1'b0;
          out_mask_nxt  = ov_ext[MASK_W-1:0];
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_mask_r <= out_mask_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.overdue_mask = out_mask_r;
  assign out_ch.last         = out_last_r;

  // at most one cell holds the scan token
  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_v))
    else $error("scan token in more than one cell");

  // no token left in the row once idle
  a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (tok_v == '0))
    else $error("scan token alive while idle");

  // token leaving the last cell moves the controller to the summary
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (op.step && tok_v[LINE_COUNT-1]) |=> (state_r == S_SUM))
    else $error("scan end missed");

  // only breach events are non-final, and only inside a check
  a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |->
      ((out_kind_r == RES_EVENT) && (state_r != S_IDLE)))
    else $error("non-final result outside a check");

endmodule
